// ===== rtl/adpd_pkg.sv =====
// Shared types and constants for the addressed packet deframer.
`timescale 1ns / 1ps

package adpd_pkg;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int SHIFT_W = 24;
  localparam int COUNT_W = 11;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  // Largest payload length (in the length word's units) that is not oversize.
  localparam logic [WORD_W-1:0] MAX_PAYLOAD_BYTES = 32'd1024;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ADDRESS   = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DELIVER_LIMIT = 8'd1;

  // Configuration register reset values.
  localparam logic [WORD_W-1:0]  OWN_ADDRESS_RST   = 32'd0;
  localparam logic [COUNT_W-1:0] DELIVER_LIMIT_RST = 11'd1024;

  // Frame field phase codes.
  localparam logic [1:0] PH_SOURCE  = 2'd0;
  localparam logic [1:0] PH_DEST    = 2'd1;
  localparam logic [1:0] PH_LENGTH  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [1:0] LANE_LAST = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0]  own_address;
    logic [COUNT_W-1:0] deliver_limit;
  } cfg_t;

  typedef struct packed {
    logic               has_data;
    logic [BYTE_W-1:0]  data_out;
    logic               frame_done;
    logic [WORD_W-1:0]  sender;
    logic [COUNT_W-1:0] delivered_count;
    logic               oversize;
  } result_t;

endpackage

// ===== rtl/adpd_in_if.sv =====
// Receive byte channel interface.
`timescale 1ns / 1ps

interface adpd_in_if;
  logic                      valid;
  logic                      ready;
  logic [adpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/adpd_out_if.sv =====
// Result channel interface.
`timescale 1ns / 1ps

interface adpd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         has_data;
  logic [adpd_pkg::BYTE_W-1:0]  data_out;
  logic                         frame_done;
  logic [adpd_pkg::WORD_W-1:0]  sender;
  logic [adpd_pkg::COUNT_W-1:0] delivered_count;
  logic                         oversize;

  modport source (output valid, output has_data, output data_out, output frame_done,
                  output sender, output delivered_count, output oversize, input ready);
  modport sink   (input valid, input has_data, input data_out, input frame_done,
                  input sender, input delivered_count, input oversize, output ready);
endinterface

// ===== rtl/adpd_cfg_if.sv =====
// Configuration write channel interface.
`timescale 1ns / 1ps

interface adpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [adpd_pkg::CFG_ADDR_W-1:0] addr;
  logic [adpd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/adpd_cfg_regs.sv =====
// Configuration registers: own address and delivery limit.
`timescale 1ns / 1ps

module adpd_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  adpd_cfg_if.sink        cfg_if,
  output adpd_pkg::cfg_t  cfg
);

  adpd_pkg::cfg_t cfg_r;
  adpd_pkg::cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      if (cfg_if.addr == adpd_pkg::CFG_OWN_ADDRESS) begin
        cfg_nxt.own_address = cfg_if.data;
      end else if (cfg_if.addr == adpd_pkg::CFG_DELIVER_LIMIT) begin
        cfg_nxt.deliver_limit = cfg_if.data[adpd_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address   <= adpd_pkg::OWN_ADDRESS_RST;
      cfg_r.deliver_limit <= adpd_pkg::DELIVER_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/adpd_parser.sv =====
// Frame parser: word assembly, header decode and payload/completion decisions.
`timescale 1ns / 1ps

module adpd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [adpd_pkg::BYTE_W-1:0]   rx_byte,
  input  adpd_pkg::cfg_t                cfg,
  output logic                          res_valid,
  output adpd_pkg::result_t             res
);

  logic [1:0]                     lane_r, lane_nxt;
  logic [1:0]                     phase_r, phase_nxt;
  logic [adpd_pkg::SHIFT_W-1:0]   shift_r, shift_nxt;
  logic [adpd_pkg::WORD_W-1:0]    source_r, source_nxt;
  logic                           match_r, match_nxt;
  logic [adpd_pkg::WORD_W-1:0]    words_left_r, words_left_nxt;
  logic [adpd_pkg::COUNT_W-1:0]   index_r, index_nxt;
  logic                           too_long_r, too_long_nxt;
  logic [adpd_pkg::COUNT_W-1:0]   cap_r, cap_nxt;

  logic [adpd_pkg::WORD_W-1:0]    word;
  logic                           emit_data;
  logic                           frame_end;

  assign word = {rx_byte, shift_r};

  always_comb begin
    lane_nxt       = lane_r;
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    source_nxt     = source_r;
    match_nxt      = match_r;
    words_left_nxt = words_left_r;
    index_nxt      = index_r;
    too_long_nxt   = too_long_r;
    cap_nxt        = cap_r;
    frame_end      = 1'b0;
    emit_data      = (phase_r == adpd_pkg::PH_PAYLOAD) && match_r && (index_r < cap_r);

    if (emit_data) begin
      index_nxt = index_r + 1'b1;
    end

    if (lane_r != adpd_pkg::LANE_LAST) begin
      shift_nxt[adpd_pkg::BYTE_W*lane_r +: adpd_pkg::BYTE_W] = rx_byte;
      lane_nxt = lane_r + 1'b1;
    end else begin
      lane_nxt = 2'd0;
      unique case (phase_r)
        adpd_pkg::PH_SOURCE: begin
          source_nxt = word;
          phase_nxt  = adpd_pkg::PH_DEST;
        end
        adpd_pkg::PH_DEST: begin
          match_nxt = (word == cfg.own_address);
          phase_nxt = adpd_pkg::PH_LENGTH;
        end
        adpd_pkg::PH_LENGTH: begin
          words_left_nxt = word;
          too_long_nxt   = (word > adpd_pkg::MAX_PAYLOAD_BYTES);
          index_nxt      = '0;
          cap_nxt        = (word < {{(adpd_pkg::WORD_W-adpd_pkg::COUNT_W){1'b0}},
                                    cfg.deliver_limit})
                           ? word[adpd_pkg::COUNT_W-1:0] : cfg.deliver_limit;
          // A zero-length frame ends on its length word.
          if (word != '0) begin
            phase_nxt = adpd_pkg::PH_PAYLOAD;
          end else begin
            phase_nxt = adpd_pkg::PH_SOURCE;
            frame_end = 1'b1;
          end
        end
        adpd_pkg::PH_PAYLOAD: begin
          if (words_left_r > 32'd1) begin
            words_left_nxt = words_left_r - 1'b1;
          end else begin
            words_left_nxt = '0;
            phase_nxt      = adpd_pkg::PH_SOURCE;
            frame_end      = 1'b1;
          end
        end
        default: begin
          phase_nxt = adpd_pkg::PH_SOURCE;
        end
      endcase
    end
  end

  // The last delivered byte always comes before the frame's last byte, so a
  // data item and a completion never coincide.
  always_comb begin
    res_valid           = accept && (emit_data || (frame_end && match_r));
    res.has_data        = emit_data;
    res.data_out        = emit_data ? rx_byte : '0;
    res.frame_done      = frame_end && match_r;
    res.sender          = source_r;
    res.delivered_count = index_nxt;
    res.oversize        = too_long_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r       <= 2'd0;
      phase_r      <= adpd_pkg::PH_SOURCE;
      shift_r      <= '0;
      source_r     <= '0;
      match_r      <= 1'b0;
      words_left_r <= '0;
      index_r      <= '0;
      too_long_r   <= 1'b0;
      cap_r        <= '0;
    end else if (accept) begin
      lane_r       <= lane_nxt;
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      source_r     <= source_nxt;
      match_r      <= match_nxt;
      words_left_r <= words_left_nxt;
      index_r      <= index_nxt;
      too_long_r   <= too_long_nxt;
      cap_r        <= cap_nxt;
    end
  end

endmodule

// ===== rtl/adpd_out_stage.sv =====
// Result register that drives the output channel.
`timescale 1ns / 1ps

module adpd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               res_valid,
  input  adpd_pkg::result_t  res,
  output logic               can_take,
  adpd_out_if.source         out_if
);

  logic              valid_r, valid_nxt;
  adpd_pkg::result_t item_r;

  // A new input may enter whenever the held result is absent or leaving.
  assign can_take = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = res_valid;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      item_r <= res;
    end
  end

  assign out_if.valid           = valid_r;
  assign out_if.has_data        = item_r.has_data;
  assign out_if.data_out        = item_r.data_out;
  assign out_if.frame_done      = item_r.frame_done;
  assign out_if.sender          = item_r.sender;
  assign out_if.delivered_count = item_r.delivered_count;
  assign out_if.oversize        = item_r.oversize;

endmodule

// ===== rtl/addressed_packet_deframer_unit.sv =====
// Top level of the addressed packet deframer.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                            Handshake
// in_if     in   rx_byte[7:0]                                       valid/ready
// out_if    out  has_data, data_out[7:0], frame_done, sender[31:0],
//                delivered_count[10:0], oversize                    valid/ready
// cfg_if    in   addr[7:0], data[31:0]                              valid/ready
//
// Each received byte is handled when it is accepted: the parser state and, when the
// byte yields a result, the output register are both updated at the edge where
// the input transaction completes. A result appears on out_if from that register.
// One byte per cycle is sustained while out_if keeps taking results; a stalled
// result holds in_if only while the output register is full and not drained.
// rst_n is synchronous and active low; the block is ready as soon as reset is
// released, and cfg_if is always ready.

module addressed_packet_deframer_unit (
  input  logic         clk,
  input  logic         rst_n,
  adpd_in_if.sink      in_if,
  adpd_out_if.source   out_if,
  adpd_cfg_if.sink     cfg_if
);

  adpd_pkg::cfg_t    cfg;
  adpd_pkg::result_t res;
  logic              res_valid;
  logic              can_take;
  logic              accept;

  // Bytes are taken whenever the output register can absorb a possible result.
  assign in_if.ready = can_take;
  assign accept      = in_if.valid && can_take;

  adpd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Word assembly, header decode, delivery cap and completion detection.
  adpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_if.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  adpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_if    (out_if)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the addressed packet deframer unit.
`timescale 1ns / 1ps

module tb_top;
  import adpd_pkg::*;

  // Longest run of cycles without any accepted transaction before the run is abandoned.
  localparam int IDLE_LIMIT = 2000;
  // Cycles allowed after the last expected result before the configuration changes.
  localparam int SETTLE_CYCLES = 4;
  // Rough number of received bytes in the random part.
  localparam int RANDOM_BYTES = 1100;
  // A register index that the block does not implement.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 8'hA7;
  localparam logic [COUNT_W-1:0] LIMIT_TOP = 11'd2047;

  // Tracks the frame parser and holds the results that the block owes, oldest first.
  class frame_tracker;
    logic [WORD_W-1:0]  station;
    logic [COUNT_W-1:0] byte_limit;
    logic [1:0]         lane;
    logic [1:0]         phase;
    logic [SHIFT_W-1:0] low_bytes;
    logic [WORD_W-1:0]  src_word;
    bit                 dest_hit;
    logic [WORD_W-1:0]  words_due;
    logic [COUNT_W-1:0] sent_bytes;
    bit                 long_frame;
    logic [COUNT_W-1:0] byte_cap;
    result_t            due_results[$];
    int                 fail_count;

    function new();
      station    = OWN_ADDRESS_RST;
      byte_limit = DELIVER_LIMIT_RST;
      lane       = '0;
      phase      = PH_SOURCE;
      low_bytes  = '0;
      src_word   = '0;
      dest_hit   = 1'b0;
      words_due  = '0;
      sent_bytes = '0;
      long_frame = 1'b0;
      byte_cap   = '0;
      fail_count = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_OWN_ADDRESS:   station = val[WORD_W-1:0];
        CFG_DELIVER_LIMIT: byte_limit = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void queue_result(bit is_data, logic [BYTE_W-1:0] b, bit done);
      result_t r;
      r.has_data        = is_data;
      r.data_out        = b;
      r.frame_done      = done;
      r.sender          = src_word;
      r.delivered_count = sent_bytes;
      r.oversize        = long_frame;
      due_results.push_back(r);
    endfunction

    function void absorb_byte(logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] word;
      bit emit;
      bit frame_end;
      emit = 1'b0;
      frame_end = 1'b0;
      // A payload byte is delivered while the latched cap is not yet used up.
      if (phase == PH_PAYLOAD && dest_hit && sent_bytes < byte_cap) begin
        sent_bytes = sent_bytes + 1'b1;
        emit = 1'b1;
      end
      if (lane != LANE_LAST) begin
        low_bytes = low_bytes | ({{(SHIFT_W-BYTE_W){1'b0}}, b} << (BYTE_W * lane));
        lane = lane + 1'b1;
        if (emit) queue_result(1'b1, b, 1'b0);
        return;
      end
      word = {b, low_bytes};
      low_bytes = '0;
      lane = '0;
      case (phase)
        PH_SOURCE: begin
          src_word = word;
          phase = PH_DEST;
        end
        PH_DEST: begin
          dest_hit = (word == station);
          phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          words_due = word;
          long_frame = (word > MAX_PAYLOAD_BYTES);
          sent_bytes = '0;
          // The cap compares the word count with the byte limit, as the block does.
          byte_cap = (word < {{(WORD_W-COUNT_W){1'b0}}, byte_limit}) ?
                     word[COUNT_W-1:0] : byte_limit;
          if (word != '0) begin
            phase = PH_PAYLOAD;
          end else begin
            phase = PH_SOURCE;
            frame_end = 1'b1;
          end
        end
        default: begin
          if (words_due > 1) begin
            words_due = words_due - 1'b1;
            if (emit) queue_result(1'b1, b, 1'b0);
          end else begin
            words_due = '0;
            phase = PH_SOURCE;
            frame_end = 1'b1;
          end
        end
      endcase
      if (frame_end && dest_hit) queue_result(1'b0, '0, 1'b1);
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected result: has_data %0b data %02h done %0b sender %08h",
                   $time, got.has_data, got.data_out, got.frame_done, got.sender);
        return;
      end
      want = due_results.pop_front();
      if (got.has_data !== want.has_data || got.data_out !== want.data_out ||
          got.frame_done !== want.frame_done || got.sender !== want.sender ||
          got.delivered_count !== want.delivered_count || got.oversize !== want.oversize) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] result mismatch (expected/actual): has_data %0b/%0b data %02h/%02h",
                   $time, want.has_data, got.has_data, want.data_out, got.data_out);
          $display("  done %0b/%0b sender %08h/%08h count %0d/%0d oversize %0b/%0b",
                   want.frame_done, got.frame_done, want.sender, got.sender,
                   want.delivered_count, got.delivered_count, want.oversize, got.oversize);
        end
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  adpd_in_if  rx_ch ();
  adpd_out_if res_ch ();
  adpd_cfg_if reg_ch ();

  frame_tracker tracker;

  // When set, the sender or the receiver runs without idle cycles.
  bit source_steady;
  bit sink_steady;
  int bytes_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  addressed_packet_deframer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (rx_ch),
    .out_if (res_ch),
    .cfg_if (reg_ch)
  );

  // Every completed transaction is seen here, at the edge where it completes. The
  // values read are the ones from before the edge, so the order of processes does
  // not matter. A result is compared before the byte of the same edge is taken,
  // since that result always belongs to an earlier byte.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (reg_ch.valid && reg_ch.ready) tracker.set_reg(reg_ch.addr, reg_ch.data);
      if (res_ch.valid && res_ch.ready) begin
        got.has_data        = res_ch.has_data;
        got.data_out        = res_ch.data_out;
        got.frame_done      = res_ch.frame_done;
        got.sender          = res_ch.sender;
        got.delivered_count = res_ch.delivered_count;
        got.oversize        = res_ch.oversize;
        tracker.compare_result(got);
      end
      if (rx_ch.valid && rx_ch.ready) tracker.absorb_byte(rx_ch.rx_byte);
    end
  end

  // The run is abandoned when no transaction of any kind completes for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (reg_ch.valid && reg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL addressed_packet_deframer_unit");
    $finish;
  end

  // The receiver holds ready low for a random number of cycles before each result,
  // unless it is in a steady stretch. Ready changes at most once per edge.
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // One received byte as one transaction, after a random gap. Valid is only
  // lowered when a gap follows, so a back-to-back byte keeps it high.
  task automatic push_rx_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!(rx_ch.valid && rx_ch.ready));
    bytes_sent++;
  endtask

  // Words go out on the wire least significant byte first.
  task automatic push_rx_word(input logic [WORD_W-1:0] w);
    for (int k = 0; k < 4; k++) push_rx_byte(w[BYTE_W*k +: BYTE_W]);
  endtask

  task automatic send_header(input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] dst,
                             input logic [WORD_W-1:0] len);
    push_rx_word(src);
    push_rx_word(dst);
    push_rx_word(len);
  endtask

  task automatic send_payload(input int words);
    for (int i = 0; i < 4 * words; i++) push_rx_byte(BYTE_W'($urandom));
  endtask

  // The sender stops and waits until every owed result has come out, then lets the
  // block settle. Configuration is only written after this.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transaction, after which valid is lowered again.
  task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.addr  <= idx;
    reg_ch.data  <= val;
    do @(posedge clk); while (!(reg_ch.valid && reg_ch.ready));
    reg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly frames for this station with small lengths; the rest are addressed
  // elsewhere, either one bit away from the own address or anywhere.
  task automatic send_random_frame();
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] len;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) dst = tracker.station;
    else if (pick < 90) dst = tracker.station ^ (32'd1 << $urandom_range(0, 31));
    else dst = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 12) len = '0;
    else if (pick < 75) len = $urandom_range(1, 8);
    else len = $urandom_range(9, 40);
    send_header($urandom, dst, len);
    send_payload(len);
  endtask

  initial begin : stimulus
    int random_start;
    int nframes;
    logic [WORD_W-1:0]  own_pick;
    logic [COUNT_W-1:0] limit_pick;
    tracker = new();
    bytes_sent = 0;
    source_steady = 1'b1;
    sink_steady   = 1'b1;
    rst_n         <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    reg_ch.valid  <= 1'b0;
    reg_ch.addr   <= '0;
    reg_ch.data   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration, no idling: a zero-length frame completes at its length
    // word, then a short frame carries the byte extremes.
    send_header(32'hA5A5_0001, OWN_ADDRESS_RST, 32'd0);
    send_header(32'hFFFF_FFFF, OWN_ADDRESS_RST, 32'd2);
    push_rx_word(32'hFF00_7F80);
    push_rx_word(32'h01FE_55AA);
    drain();

    // Top address, a limit of zero and a write to an unknown index. The matching
    // frame delivers nothing but still completes; the near miss is consumed.
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    program_reg(CFG_OWN_ADDRESS, 32'hFFFF_FFFF);
    program_reg(CFG_DELIVER_LIMIT, 32'd0);
    program_reg(CFG_UNMAPPED, $urandom);
    send_header(32'h1234_5678, 32'hFFFF_FFFF, 32'd1);
    push_rx_word($urandom);
    send_header(32'h8765_4321, 32'hFFFF_FFFE, 32'd0);
    drain();

    // The limit changes after the length word: the cap taken at the length word holds.
    program_reg(CFG_DELIVER_LIMIT, 32'd3);
    send_header(32'h0000_0000, 32'hFFFF_FFFF, 32'd3);
    drain();
    program_reg(CFG_DELIVER_LIMIT, 32'd0);
    send_payload(3);

    // Random phases. Each starts from an idle block with a fresh configuration;
    // stray upper bits in the limit write must be dropped.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      drain();
      case ($urandom_range(0, 3))
        0:       own_pick = '0;
        1:       own_pick = '1;
        default: own_pick = $urandom;
      endcase
      case ($urandom_range(0, 6))
        0:       limit_pick = '0;
        1:       limit_pick = 11'd1;
        2:       limit_pick = $urandom_range(2, 16);
        3:       limit_pick = $urandom_range(0, 1024);
        4:       limit_pick = DELIVER_LIMIT_RST;
        5:       limit_pick = LIMIT_TOP;
        default: limit_pick = $urandom_range(1025, 2047);
      endcase
      program_reg(CFG_OWN_ADDRESS, own_pick);
      program_reg(CFG_DELIVER_LIMIT, ($urandom & 32'hFFFF_F800) | limit_pick);
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      nframes = $urandom_range(3, 8);
      repeat (nframes) send_random_frame();
    end
    drain();
    source_steady = 1'b0;
    sink_steady   = 1'b0;

    // A frame with the largest length word is left open: its bytes up to the limit
    // come out flagged oversize, and the run ends in the middle of it.
    program_reg(CFG_DELIVER_LIMIT, 32'd20);
    send_header($urandom, tracker.station, 32'hFFFF_FFFF);
    send_payload(8);
    drain();

    if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
      $display("PASS addressed_packet_deframer_unit");
    end else begin
      $display("FAIL addressed_packet_deframer_unit");
    end
    $finish;
  end

endmodule

// ===== addressed_packet_deframer_unit.f =====
rtl/adpd_pkg.sv
rtl/adpd_in_if.sv
rtl/adpd_out_if.sv
rtl/adpd_cfg_if.sv
rtl/adpd_cfg_regs.sv
rtl/adpd_parser.sv
rtl/adpd_out_stage.sv
rtl/addressed_packet_deframer_unit.sv
bench/tb_top.sv
